### hw/rtl/klq_pkg.sv
`timescale 1ns / 1ps
// KeeLoq cipher package: stage payload type, round constants and round functions.
// No dependencies; used by klq_cell and keeloq_block_cipher.
package klq_pkg;

    localparam int TOTAL_ROUNDS = 528;
    localparam int KEY_W        = 64;
    localparam int KEY_IDX_W    = 6;
    localparam int DATA_W       = 32;
    localparam int DEC_OFFSET   = 15;

    localparam logic [31:0] NLF_TABLE = 32'h3A5C742E;

    typedef enum logic {
        OP_ENCRYPT = 1'b0,
        OP_DECRYPT = 1'b1
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [DATA_W-1:0]  data;
        logic [KEY_W-1:0]   key;
    } t_stage;

    // Encrypt round: shift right, feedback into bit 31
    function automatic logic [DATA_W-1:0] enc_round(input logic [DATA_W-1:0] x,
                                                    input logic kb);
        logic [4:0] idx;
        logic       fb;
        idx = {x[31], x[26], x[20], x[9], x[1]};
        fb  = x[0] ^ x[16] ^ kb ^ NLF_TABLE[idx];
        return {fb, x[DATA_W-1:1]};
    endfunction

    // Decrypt round: shift left, feedback into bit 0
    function automatic logic [DATA_W-1:0] dec_round(input logic [DATA_W-1:0] x,
                                                    input logic kb);
        logic [4:0] idx;
        logic       fb;
        idx = {x[30], x[25], x[19], x[8], x[0]};
        fb  = x[31] ^ x[15] ^ kb ^ NLF_TABLE[idx];
        return {x[DATA_W-2:0], fb};
    endfunction

endpackage

### hw/rtl/keeloq_block_cipher.sv
`timescale 1ns / 1ps
// KeeLoq block cipher: a chain of ceil(528 / ROUNDS_PER_CELL) cells, 66 at the default.
// Each cell registers its result, so a block passes through every cell's register between input transfer and o_valid.
// Throughput: one block per cycle while i_stall is low, set by one cell of ROUNDS_PER_CELL rounds per stage.
// Stalls ripple back only through occupied cells; empty cells keep taking data.
// Synchronous active-low reset clears every cell's valid bit; payload is not reset.
module keeloq_block_cipher #(
    parameter int ROUNDS_PER_CELL = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_op,
    input  logic [31:0] i_data_word,
    input  logic [63:0] i_cipher_key,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_result_word
);
    import klq_pkg::*;

    localparam int NUM_CELLS = (TOTAL_ROUNDS + ROUNDS_PER_CELL - 1) / ROUNDS_PER_CELL;

    logic   s_valid [NUM_CELLS+1];
    t_stage s_stage [NUM_CELLS+1];
    logic   s_stall [NUM_CELLS+1];

    assign s_valid[0]      = i_valid;
    assign s_stage[0].op   = t_op'(i_op);
    assign s_stage[0].data = i_data_word;
    assign s_stage[0].key  = i_cipher_key;
    assign o_stall         = s_stall[0];

    for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
        localparam int BASE = c * ROUNDS_PER_CELL;
        localparam int LEFT = TOTAL_ROUNDS - BASE;
        localparam int NR   = (LEFT < ROUNDS_PER_CELL) ? LEFT : ROUNDS_PER_CELL;

        klq_cell #(
            .BASE_ROUND (BASE),
            .N_ROUNDS   (NR)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (s_valid[c]),
            .i_stage (s_stage[c]),
            .i_stall (s_stall[c+1]),
            .o_valid (s_valid[c+1]),
            .o_stage (s_stage[c+1]),
            .o_stall (s_stall[c])
        );
    end

    assign s_stall[NUM_CELLS] = i_stall;
    assign o_valid            = s_valid[NUM_CELLS];
    assign o_result_word      = s_stage[NUM_CELLS].data;

`ifndef SYNTHESIS
    a_stall_from_sink: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (i_stall && o_valid))
        else $error("input stalled while output side is free");

    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_result_word)))
        else $error("stalled result changed");

    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !o_stall))
        else $error("output valid after reset");
`endif

endmodule

### hw/rtl/klq_cell.sv
`timescale 1ns / 1ps
// One pipeline cell of the KeeLoq round chain: runs N_ROUNDS rounds from BASE_ROUND.
// Depends on klq_pkg.
module klq_cell #(
    parameter int BASE_ROUND = 0,
    parameter int N_ROUNDS   = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  klq_pkg::t_stage i_stage,
    input  logic            i_stall,
    output logic            o_valid,
    output klq_pkg::t_stage o_stage,
    output logic            o_stall
);
    import klq_pkg::*;

    logic                  r_valid;
    t_stage                r_stage;
    logic [DATA_W-1:0]     n_data;

    // hold while a result sits here and the next cell cannot take it
    assign o_stall = r_valid & i_stall;

    always_comb begin
        logic [DATA_W-1:0]    x;
        logic [KEY_IDX_W-1:0] ki;
        x  = i_stage.data;
        ki = '0;
        for (int k = 0; k < N_ROUNDS; k++) begin
            if (i_stage.op == OP_DECRYPT) begin
                ki = KEY_IDX_W'(DEC_OFFSET - BASE_ROUND - k);
                x  = dec_round(x, i_stage.key[ki]);
            end else begin
                ki = KEY_IDX_W'(BASE_ROUND + k);
                x  = enc_round(x, i_stage.key[ki]);
            end
        end
        n_data = x;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_stage.op   <= i_stage.op;
            r_stage.key  <= i_stage.key;
            r_stage.data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

`ifndef SYNTHESIS
    a_hold_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && i_stall) |=> (r_valid && $stable(r_stage)))
        else $error("cell lost or changed a stalled item");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_stall && i_valid) |=> r_valid)
        else $error("cell dropped an incoming item");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_valid)
        else $error("cell valid not cleared by reset");
`endif

endmodule

### tb/tb_keeloq_block_cipher.sv
`timescale 1ns / 1ps
// Self-checking testbench for keeloq_block_cipher: 528-round encrypt/decrypt predictor,
// random idling on both sides, back-pressure fill. Depends on klq_pkg and the cipher RTL.
module tb_keeloq_block_cipher;
    import klq_pkg::*;

    localparam int PIPE_DEPTH = 66;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic        i_op;
    logic [31:0] i_data_word;
    logic [63:0] i_cipher_key;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_result_word;

    logic [31:0] expected_words[$];
    int          mismatches   = 0;
    int          results_seen = 0;
    int          hold_cycles  = 0;
    bit          tx_idle_en   = 1'b0;
    bit          rx_idle_en   = 1'b0;

    keeloq_block_cipher uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_op          (i_op),
        .i_data_word   (i_data_word),
        .i_cipher_key  (i_cipher_key),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_result_word (o_result_word)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // Full 528-round NLFSR over one block
    function automatic logic [31:0] keeloq_transform(input t_op op, input logic [31:0] blk,
                                                     input logic [63:0] key);
        logic [31:0] x;
        logic [4:0]  sel;
        logic        fb;
        int          kidx;
        x = blk;
        for (int r = 0; r < TOTAL_ROUNDS; r++) begin
            if (op == OP_ENCRYPT) begin
                sel  = {x[31], x[26], x[20], x[9], x[1]};
                kidx = r & 63;
                fb   = x[0] ^ x[16] ^ key[kidx] ^ NLF_TABLE[sel];
                x    = {fb, x[31:1]};
            end else begin
                sel  = {x[30], x[25], x[19], x[8], x[0]};
                kidx = (DEC_OFFSET - r) & 63;
                fb   = x[31] ^ x[15] ^ key[kidx] ^ NLF_TABLE[sel];
                x    = {x[30:0], fb};
            end
        end
        return x;
    endfunction

    // mostly short, occasionally long
    function automatic int idle_len();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_block(input t_op op, input logic [31:0] blk, input logic [63:0] key);
        int gap;
        gap = (tx_idle_en && $urandom_range(0, 99) < 25) ? idle_len() : 0;
        repeat (gap) begin
            @(negedge i_clk);
            i_valid     = 1'b0;
            i_data_word = $urandom;
        end
        @(negedge i_clk);
        i_valid      = 1'b1;
        i_op         = op;
        i_data_word  = blk;
        i_cipher_key = key;
        do @(posedge i_clk); while (o_stall);
        expected_words.push_back(keeloq_transform(op, blk, key));
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (expected_words.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic test_directed_vectors();
        logic [31:0] blks[6];
        logic [63:0] keys[6];
        logic [31:0] ct;
        blks = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h5555_5555,
                 32'hAAAA_AAAA, 32'h0000_0001, 32'h8000_0000};
        keys = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'hAAAA_AAAA_AAAA_AAAA,
                 64'h5555_5555_5555_5555, 64'h8000_0000_0000_0000, 64'h1};
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        for (int i = 0; i < 6; i++) begin
            send_block(OP_ENCRYPT, blks[i], keys[i]);
            send_block(OP_DECRYPT, blks[i], keys[i]);
        end
        // encrypt then decrypt the ciphertext back
        ct = keeloq_transform(OP_ENCRYPT, 32'h1234_5678, 64'h0123_4567_89AB_CDEF);
        send_block(OP_ENCRYPT, 32'h1234_5678, 64'h0123_4567_89AB_CDEF);
        send_block(OP_DECRYPT, ct, 64'h0123_4567_89AB_CDEF);
        drain_results();
    endtask

    task automatic test_random_traffic(input int n);
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        repeat (n)
            send_block(t_op'($urandom_range(0, 1)), $urandom, {$urandom, $urandom});
        drain_results();
    endtask

    task automatic test_back_to_back(input int n);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        repeat (n)
            send_block(t_op'($urandom_range(0, 1)), $urandom, {$urandom, $urandom});
        drain_results();
    endtask

    // receiver holds off long enough for the whole chain to fill and stall the input
    task automatic test_backpressure_fill(input int n);
        tx_idle_en  = 1'b0;
        rx_idle_en  = 1'b1;
        hold_cycles = 4 * PIPE_DEPTH + 40;
        repeat (n)
            send_block(t_op'($urandom_range(0, 1)), $urandom, {$urandom, $urandom});
        drain_results();
    endtask

    task automatic test_roundtrip(input int pairs);
        logic [31:0] pt;
        logic [63:0] key;
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        repeat (pairs) begin
            pt  = $urandom;
            key = {$urandom, $urandom};
            send_block(OP_ENCRYPT, pt, key);
            send_block(OP_DECRYPT, keeloq_transform(OP_ENCRYPT, pt, key), key);
        end
        drain_results();
    endtask

    // receiver side: random stalls plus the long hold-off, counted here
    initial begin
        int stall_left;
        stall_left = 0;
        i_stall    = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                i_stall = 1'b1;
                hold_cycles--;
            end else if (stall_left > 0) begin
                i_stall = 1'b1;
                stall_left--;
            end else begin
                i_stall = 1'b0;
                if (rx_idle_en && $urandom_range(0, 99) < 20)
                    stall_left = idle_len();
            end
        end
    end

    always @(posedge i_clk) begin
        logic [31:0] want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_words.size() == 0) begin
                if (mismatches < 10)
                    $display("result transfer %0d: unexpected, got %h",
                             results_seen, o_result_word);
                mismatches++;
            end else begin
                want = expected_words.pop_front();
                if (o_result_word !== want) begin
                    if (mismatches < 10)
                        $display("result transfer %0d: result_word expected %h got %h",
                                 results_seen, want, o_result_word);
                    mismatches++;
                end
            end
            results_seen++;
        end
    end

    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_op         = OP_ENCRYPT;
        i_data_word  = '0;
        i_cipher_key = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_vectors();
        test_random_traffic(200);
        test_back_to_back(100);
        test_backpressure_fill(150);
        test_roundtrip(40);

        // let any stray transfer surface before the verdict
        repeat (PIPE_DEPTH + 20) @(posedge i_clk);
        if (mismatches == 0 && expected_words.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
